[hdl/clc_pkg.sv]
package clc_pkg;

    // list sizing
    localparam int CAPACITY       = 16;
    localparam int VALUE_BITS     = 32;
    localparam int COUNT_BITS     = $clog2(CAPACITY + 1);

    // port widths fixed by the interface
    localparam int ITEM_BITS      = 32;
    localparam int COUNT_OUT_BITS = 7;

    typedef enum logic [1:0] {
        OP_INS_HEAD = 2'd0,
        OP_INS_TAIL = 2'd1,
        OP_DELETE   = 2'd2,
        OP_READ     = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    // what every cell of the row does in one cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHIFT_R,
        CELL_LOAD_TAIL,
        CELL_ROTATE,
        CELL_DROP
    } t_cell_op;

    // command from the controller to the whole row
    typedef struct packed {
        t_cell_op                op;
        logic [VALUE_BITS-1:0]   new_val;
        logic [COUNT_BITS-1:0]   count;
    } t_chain_ctl;

    // command as seen by one cell
    typedef struct packed {
        t_cell_op op;
        logic     is_first;
        logic     is_end;
        logic     is_slot;
    } t_cell_ctl;

endpackage

[hdl/circular_list_engine.sv]
// channel   direction  handshake                  payload
// input     in         i_in_valid / o_in_stall    i_opcode, i_value
// output    out        o_out_valid / i_out_stall  o_status, o_item_value, o_last_item, o_count
//
// entries sit in list order in a row of cells, head in the first cell.
// insert passes through the insert and response states to its result; delete and read-out
// rotate the list, one rotation step of the row per cycle, read-out sending one item per step.
// reset (synchronous, active low) empties the list; cell contents are not cleared.
// a stalled output holds the read-out rotation; one item is worked on at a time.
module circular_list_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_item_value,
    output logic               o_last_item,
    output logic [6:0]         o_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_DELETE,
        S_READ,
        S_RESP
    } t_state;

    t_state                                  r_state;
    clc_pkg::t_opcode                        r_op;
    logic [clc_pkg::VALUE_BITS-1:0]          r_val;
    logic [clc_pkg::COUNT_BITS-1:0]          r_count;
    logic [clc_pkg::COUNT_BITS-1:0]          r_rem;
    logic                                    r_found;
    clc_pkg::t_status                        r_status;
    logic                                    r_out_valid;
    clc_pkg::t_status                        r_out_status;
    logic [clc_pkg::ITEM_BITS-1:0]           r_out_val;
    logic                                    r_out_last;
    logic [clc_pkg::COUNT_BITS-1:0]          r_out_count;

    clc_pkg::t_chain_ctl                     w_chain_ctl;
    logic [clc_pkg::VALUE_BITS-1:0]          w_head_val;
    logic                                    w_match;
    logic                                    w_out_free;
    logic                                    w_full;

    assign w_match    = (w_head_val == r_val);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_full     = (r_count == clc_pkg::COUNT_BITS'(clc_pkg::CAPACITY));

    // row command for this cycle
    always_comb begin
        w_chain_ctl.op      = clc_pkg::CELL_HOLD;
        w_chain_ctl.new_val = r_val;
        w_chain_ctl.count   = r_count;
        unique case (r_state)
            S_INSERT: begin
                if (!w_full) begin
                    w_chain_ctl.op = (r_op == clc_pkg::OP_INS_HEAD) ?
                                     clc_pkg::CELL_SHIFT_R : clc_pkg::CELL_LOAD_TAIL;
                end
            end
            S_DELETE: begin
                w_chain_ctl.op = (w_match && !r_found) ?
                                 clc_pkg::CELL_DROP : clc_pkg::CELL_ROTATE;
            end
            S_READ: begin
                if (w_out_free) begin
                    w_chain_ctl.op = clc_pkg::CELL_ROTATE;
                end
            end
            S_IDLE, S_RESP: begin
                w_chain_ctl.op = clc_pkg::CELL_HOLD;
            end
            default: begin
                w_chain_ctl.op = clc_pkg::CELL_HOLD;
            end
        endcase
    end

    clc_chain u_chain (
        .i_clk      (i_clk),
        .i_ctl      (w_chain_ctl),
        .o_head_val (w_head_val)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // states that load the output register set valid themselves
            if (r_out_valid && !i_out_stall && r_state != S_READ && r_state != S_RESP) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= clc_pkg::t_opcode'(i_opcode);
                        r_val   <= clc_pkg::VALUE_BITS'($unsigned(i_value));
                        r_rem   <= r_count;
                        r_found <= 1'b0;
                        unique case (clc_pkg::t_opcode'(i_opcode))
                            clc_pkg::OP_INS_HEAD, clc_pkg::OP_INS_TAIL: begin
                                r_state <= S_INSERT;
                            end
                            clc_pkg::OP_DELETE: begin
                                if (r_count == '0) begin
                                    r_status <= clc_pkg::ST_EMPTY;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_state  <= S_DELETE;
                                end
                            end
                            clc_pkg::OP_READ: begin
                                if (r_count == '0) begin
                                    r_status <= clc_pkg::ST_EMPTY;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_state  <= S_READ;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_INSERT: begin
                    if (w_full) begin
                        r_status <= clc_pkg::ST_FULL;
                    end else begin
                        r_status <= clc_pkg::ST_OK;
                        r_count  <= clc_pkg::COUNT_BITS'(r_count + clc_pkg::COUNT_BITS'(1));
                    end
                    r_state <= S_RESP;
                end
                S_DELETE: begin
                    // head cell is compared as the list rotates past it
                    if (w_match && !r_found) begin
                        r_found <= 1'b1;
                        r_count <= clc_pkg::COUNT_BITS'(r_count - clc_pkg::COUNT_BITS'(1));
                    end
                    r_rem <= clc_pkg::COUNT_BITS'(r_rem - clc_pkg::COUNT_BITS'(1));
                    if (r_rem == clc_pkg::COUNT_BITS'(1)) begin
                        r_status <= (r_found || w_match) ? clc_pkg::ST_OK : clc_pkg::ST_NOTFOUND;
                        r_state  <= S_RESP;
                    end
                end
                S_READ: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= clc_pkg::ST_OK;
                        r_out_val    <= clc_pkg::ITEM_BITS'(w_head_val);
                        r_out_last   <= (r_rem == clc_pkg::COUNT_BITS'(1));
                        r_out_count  <= r_count;
                        r_rem        <= clc_pkg::COUNT_BITS'(r_rem - clc_pkg::COUNT_BITS'(1));
                        if (r_rem == clc_pkg::COUNT_BITS'(1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_RESP: begin
                    if (w_out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_val    <= '0;
                        r_out_last   <= 1'b1;
                        r_out_count  <= r_count;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_item_value = $signed(r_out_val);
    assign o_last_item  = r_out_last;
    assign o_count      = clc_pkg::COUNT_OUT_BITS'(r_out_count);

endmodule

[hdl/clc_cell.sv]
module clc_cell (
    input  logic                              i_clk,
    input  clc_pkg::t_cell_ctl                i_ctl,
    input  logic [clc_pkg::VALUE_BITS-1:0]    i_new_val,
    input  logic [clc_pkg::VALUE_BITS-1:0]    i_left_val,
    input  logic [clc_pkg::VALUE_BITS-1:0]    i_right_val,
    input  logic [clc_pkg::VALUE_BITS-1:0]    i_wrap_val,
    output logic [clc_pkg::VALUE_BITS-1:0]    o_val
);

    logic [clc_pkg::VALUE_BITS-1:0] r_val;
    logic [clc_pkg::VALUE_BITS-1:0] n_val;

    // next value picked from self, neighbours, head or new entry
    always_comb begin
        n_val = r_val;
        unique case (i_ctl.op)
            clc_pkg::CELL_HOLD: begin
                n_val = r_val;
            end
            clc_pkg::CELL_SHIFT_R: begin
                n_val = i_ctl.is_first ? i_new_val : i_left_val;
            end
            clc_pkg::CELL_LOAD_TAIL: begin
                if (i_ctl.is_slot) begin
                    n_val = i_new_val;
                end
            end
            clc_pkg::CELL_ROTATE: begin
                n_val = i_ctl.is_end ? i_wrap_val : i_right_val;
            end
            clc_pkg::CELL_DROP: begin
                n_val = i_right_val;
            end
            default: begin
                n_val = r_val;
            end
        endcase
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

[hdl/clc_chain.sv]
module clc_chain (
    input  logic                              i_clk,
    input  clc_pkg::t_chain_ctl               i_ctl,
    output logic [clc_pkg::VALUE_BITS-1:0]    o_head_val
);

    logic [clc_pkg::VALUE_BITS-1:0] w_val [clc_pkg::CAPACITY];
    clc_pkg::t_cell_ctl             w_ctl [clc_pkg::CAPACITY];
    logic [clc_pkg::COUNT_BITS-1:0] w_end_idx;

    // last occupied position, wraps round to the head on a rotate
    assign w_end_idx = clc_pkg::COUNT_BITS'(i_ctl.count - clc_pkg::COUNT_BITS'(1));

    genvar g;
    generate
        for (g = 0; g < clc_pkg::CAPACITY; g++) begin : g_cell
            logic [clc_pkg::VALUE_BITS-1:0] w_left;
            logic [clc_pkg::VALUE_BITS-1:0] w_right;

            // per-position decode of the row command
            assign w_ctl[g].op       = i_ctl.op;
            assign w_ctl[g].is_first = (g == 0);
            assign w_ctl[g].is_end   = (clc_pkg::COUNT_BITS'(g) == w_end_idx);
            assign w_ctl[g].is_slot  = (clc_pkg::COUNT_BITS'(g) == i_ctl.count);

            // neighbour links, the ends fold back onto the cell itself
            if (g == 0) begin : g_left_end
                assign w_left = w_val[g];
            end else begin : g_left
                assign w_left = w_val[g-1];
            end
            if (g == clc_pkg::CAPACITY - 1) begin : g_right_end
                assign w_right = w_val[g];
            end else begin : g_right
                assign w_right = w_val[g+1];
            end

            clc_cell u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl[g]),
                .i_new_val   (i_ctl.new_val),
                .i_left_val  (w_left),
                .i_right_val (w_right),
                .i_wrap_val  (w_val[0]),
                .o_val       (w_val[g])
            );
        end
    endgenerate

    assign o_head_val = w_val[0];

endmodule
